@@ rtl/gng_pkg.sv @@
// ----------------------------------------------------------------------------
// gng_pkg
// Shared types, constants and micro-sequence tables of the gaussian noise
// generator (lagged-fibonacci uniform source and box-muller transform).
// ----------------------------------------------------------------------------
package gng_pkg;

    // lag table geometry and lags
    localparam int TABLE_AW = 8;
    localparam int WORD_W   = 32;
    localparam logic [TABLE_AW-1:0] LAG_A = 8'd24;
    localparam logic [TABLE_AW-1:0] LAG_B = 8'd55;
    localparam logic [TABLE_AW-1:0] LAG_C = 8'd61;

    // stream widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_W      = 24;
    localparam int OUT_DATA_W = 48;
    localparam int STD_W      = 16;

    // fixed point constants
    localparam logic [STD_W-1:0] STD_RESET   = 16'd5793;
    localparam logic [31:0]      TWO_LN2_Q30 = 32'd1488522236;
    localparam logic [31:0]      HALF_PI_Q30 = 32'd1686629713;
    localparam logic [30:0]      ONE_Q30     = 31'h4000_0000;

    // last step of each iterative phase
    localparam logic [4:0] LOG_LAST  = 5'd25;
    localparam logic [4:0] SQRT_LAST = 5'd28;
    localparam logic [4:0] TRIG_LAST = 5'd24;

    // constant divisors of the taylor series
    typedef enum logic [3:0] {
        DIV_72,
        DIV_42,
        DIV_20,
        DIV_6,
        DIV_90,
        DIV_56,
        DIV_30,
        DIV_12,
        DIV_2
    } div_sel_t;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_UPDATE,
        OP_MIX_U1,
        OP_MIX_U2,
        OP_NORM,
        OP_LOG,
        OP_TLOG,
        OP_SCALE,
        OP_SQRT,
        OP_ANGLE,
        OP_ASQ,
        OP_WA2,
        OP_DIV,
        OP_MULW,
        OP_SIN,
        OP_RC,
        OP_EMIT1,
        OP_RS,
        OP_EMIT2,
        OP_PUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t   op;
        div_sel_t div_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic norm_done;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_MIX,
        ST_NORM,
        ST_LOG,
        ST_TLOG,
        ST_SCALE,
        ST_SQRT,
        ST_TRIG,
        ST_PUSH
    } ctrl_state_t;

    // exact reciprocal for x < 2^31: floor(x/d) = (x * magic) >> shift
    function automatic logic [31:0] div_magic(input div_sel_t sel);
        logic [31:0] m;
        case (sel)
            DIV_72:  m = 32'd3817748708;
            DIV_42:  m = 32'd3272356036;
            DIV_20:  m = 32'd3435973837;
            DIV_6:   m = 32'd2863311531;
            DIV_90:  m = 32'd3054198967;
            DIV_56:  m = 32'd2454267027;
            DIV_30:  m = 32'd2290649225;
            DIV_12:  m = 32'd2863311531;
            DIV_2:   m = 32'd2147483648;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] div_shift(input div_sel_t sel);
        logic [5:0] s;
        case (sel)
            DIV_72:  s = 6'd38;
            DIV_42:  s = 6'd37;
            DIV_20:  s = 6'd36;
            DIV_6:   s = 6'd34;
            DIV_90:  s = 6'd38;
            DIV_56:  s = 6'd37;
            DIV_30:  s = 6'd36;
            DIV_12:  s = 6'd35;
            DIV_2:   s = 6'd32;
            default: s = 6'd32;
        endcase
        return s;
    endfunction

    // angle, sine and cosine series, then the two output branches
    function automatic dp_cmd_t trig_cmd(input logic [4:0] step);
        dp_cmd_t c;
        c = '{op: OP_NONE, div_sel: DIV_72};
        case (step)
            5'd0:    c.op = OP_ANGLE;
            5'd1:    c.op = OP_ASQ;
            5'd2:    c.op = OP_WA2;
            5'd3:    c = '{op: OP_DIV, div_sel: DIV_72};
            5'd4:    c.op = OP_MULW;
            5'd5:    c = '{op: OP_DIV, div_sel: DIV_42};
            5'd6:    c.op = OP_MULW;
            5'd7:    c = '{op: OP_DIV, div_sel: DIV_20};
            5'd8:    c.op = OP_MULW;
            5'd9:    c = '{op: OP_DIV, div_sel: DIV_6};
            5'd10:   c.op = OP_SIN;
            5'd11:   c.op = OP_WA2;
            5'd12:   c = '{op: OP_DIV, div_sel: DIV_90};
            5'd13:   c.op = OP_MULW;
            5'd14:   c = '{op: OP_DIV, div_sel: DIV_56};
            5'd15:   c.op = OP_MULW;
            5'd16:   c = '{op: OP_DIV, div_sel: DIV_30};
            5'd17:   c.op = OP_MULW;
            5'd18:   c = '{op: OP_DIV, div_sel: DIV_12};
            5'd19:   c.op = OP_MULW;
            5'd20:   c = '{op: OP_DIV, div_sel: DIV_2};
            5'd21:   c.op = OP_RC;
            5'd22:   c.op = OP_EMIT1;
            5'd23:   c.op = OP_RS;
            5'd24:   c.op = OP_EMIT2;
            default: c.op = OP_NONE;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/gng_datapath.sv @@
// ----------------------------------------------------------------------------
// gng_datapath
// Lag table, uniform draws, bit-serial log2 and square root, a multiplier
// shared by log, scaling, trig series and output scaling; result registers.
// ----------------------------------------------------------------------------
module gng_datapath import gng_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  cfg_we,
    input  logic [STD_W-1:0]      cfg_wdata,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic [WORD_W-1:0] mem [2**TABLE_AW];

    logic [TABLE_AW-1:0]   ptr_reg;
    logic [STD_W-1:0]      std_reg;
    logic [WORD_W-1:0]     rd0_reg, rd1_reg, sum_reg;
    logic [31:0]           m_reg, x2_reg, tlog_reg, rem_reg;
    logic [4:0]            lz_reg;
    logic [25:0]           frac_reg;
    logic [57:0]           n_reg;
    logic [28:0]           root_reg;
    logic [29:0]           a_reg, a2_reg, w_reg;
    logic [30:0]           t_reg, sn_reg;
    logic [OUT_W-1:0]      res1_reg, res2_reg;
    logic [OUT_DATA_W-1:0] out_reg;

    logic [TABLE_AW-1:0] ra0, ra1, waddr;
    logic                we;
    logic [WORD_W-1:0]   wdata, mix;
    logic [31:0]         mul_a, mul_b, quo, remsh, trial;
    logic [63:0]         prod, rnd;
    logic [32:0]         sq;
    logic [29:0]         g;
    logic                swp, flip, neg1, neg2;
    logic [30:0]         cm, sm;

    function automatic logic [OUT_W-1:0] emit_sat(input logic [37:0] mag, input logic neg);
        logic [OUT_W-1:0] lim;
        if (neg) begin
            lim = (mag > 38'd8388608) ? 24'h800000 : mag[OUT_W-1:0];
            return ~lim + 24'd1;
        end else begin
            return (mag > 38'd8388607) ? 24'h7FFFFF : mag[OUT_W-1:0];
        end
    endfunction

    // table addressing
    always_comb begin
        ra0   = (cmd.op == OP_UPDATE) ? ptr_reg - LAG_C : ptr_reg - LAG_A;
        ra1   = ptr_reg - LAG_B;
        we    = (cmd.op == OP_LOAD) || (cmd.op == OP_UPDATE);
        waddr = (cmd.op == OP_LOAD) ? s_tdata[7:0] : ptr_reg;
        wdata = (cmd.op == OP_LOAD) ? s_tdata[39:8] : rd0_reg + rd1_reg;
        mix   = sum_reg ^ rd0_reg;
    end

    // lag table memory
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd0_reg <= mem[ra0];
        rd1_reg <= mem[ra1];
    end

    // angle folding and branch selection
    always_comb begin
        swp  = x2_reg[29];
        g    = swp ? 30'(ONE_Q30 - {1'b0, x2_reg[29:0]}) : x2_reg[29:0];
        flip = x2_reg[30] ^ swp;
        cm   = flip ? sn_reg : t_reg;
        sm   = flip ? t_reg : sn_reg;
        neg1 = ~(x2_reg[31] ^ x2_reg[30]);
        neg2 = ~x2_reg[31];
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (cmd.op)
            OP_LOG: begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            OP_SCALE: begin
                mul_a = tlog_reg;
                mul_b = TWO_LN2_Q30;
            end
            OP_ANGLE: begin
                mul_a = {2'b0, g};
                mul_b = HALF_PI_Q30;
            end
            OP_ASQ: begin
                mul_a = {2'b0, a_reg};
                mul_b = {2'b0, a_reg};
            end
            OP_DIV: begin
                mul_a = {2'b0, w_reg};
                mul_b = div_magic(cmd.div_sel);
            end
            OP_MULW: begin
                mul_a = {2'b0, a2_reg};
                mul_b = {1'b0, t_reg};
            end
            OP_SIN: begin
                mul_a = {2'b0, a_reg};
                mul_b = {1'b0, t_reg};
            end
            OP_RC: begin
                mul_a = {3'b0, root_reg};
                mul_b = {1'b0, cm};
            end
            OP_RS: begin
                mul_a = {3'b0, root_reg};
                mul_b = {1'b0, sm};
            end
            OP_EMIT1, OP_EMIT2: begin
                mul_a = {2'b0, w_reg};
                mul_b = {16'b0, std_reg};
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
        prod  = {32'b0, mul_a} * {32'b0, mul_b};
        sq    = prod[63:31];
        quo   = 32'(prod >> div_shift(cmd.div_sel));
        rnd   = prod + 64'h0000_0000_0200_0000;
        remsh = {rem_reg[29:0], n_reg[57:56]};
        trial = {1'b0, root_reg, 2'b01};
    end

    // pointer and standard deviation register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
            std_reg <= STD_RESET;
        end else begin
            if (cmd.op == OP_MIX_U1 || cmd.op == OP_MIX_U2) begin
                ptr_reg <= ptr_reg + 8'd1;
            end
            if (cfg_we) begin
                std_reg <= cfg_wdata;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_UPDATE: begin
                sum_reg <= rd0_reg + rd1_reg;
            end
            OP_MIX_U1: begin
                m_reg    <= (mix == 32'd0) ? 32'd1 : mix;
                lz_reg   <= '0;
                frac_reg <= '0;
            end
            OP_MIX_U2: begin
                x2_reg <= mix;
            end
            OP_NORM: begin
                m_reg  <= {m_reg[30:0], 1'b0};
                lz_reg <= lz_reg + 5'd1;
            end
            OP_LOG: begin
                if (sq[32]) begin
                    m_reg    <= sq[32:1];
                    frac_reg <= {frac_reg[24:0], 1'b1};
                end else begin
                    m_reg    <= sq[31:0];
                    frac_reg <= {frac_reg[24:0], 1'b0};
                end
            end
            OP_TLOG: begin
                tlog_reg <= {({1'b0, lz_reg} + 6'd1), 26'b0} - {6'b0, frac_reg};
            end
            OP_SCALE: begin
                n_reg    <= {prod[61:30], 26'b0};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_SQRT: begin
                n_reg <= {n_reg[55:0], 2'b00};
                if (remsh >= trial) begin
                    rem_reg  <= remsh - trial;
                    root_reg <= {root_reg[27:0], 1'b1};
                end else begin
                    rem_reg  <= remsh;
                    root_reg <= {root_reg[27:0], 1'b0};
                end
            end
            OP_ANGLE: begin
                a_reg <= prod[59:30];
            end
            OP_ASQ: begin
                a2_reg <= prod[59:30];
            end
            OP_WA2: begin
                w_reg <= a2_reg;
            end
            OP_DIV: begin
                t_reg <= ONE_Q30 - quo[30:0];
            end
            OP_MULW, OP_RC, OP_RS: begin
                w_reg <= prod[59:30];
            end
            OP_SIN: begin
                sn_reg <= prod[60:30];
            end
            OP_EMIT1: begin
                res1_reg <= emit_sat(rnd[63:26], neg1);
            end
            OP_EMIT2: begin
                res2_reg <= emit_sat(rnd[63:26], neg2);
            end
            OP_PUSH: begin
                out_reg <= {res2_reg, res1_reg};
            end
            default: begin
            end
        endcase
    end

    assign status.norm_done = m_reg[31];
    assign m_tdata          = out_reg;

endmodule

@@ rtl/gng_ctrl.sv @@
// ----------------------------------------------------------------------------
// gng_ctrl
// Sequencer: item handshake, draw sequence, iteration counts of the log,
// square root and trig phases, output valid.
// ----------------------------------------------------------------------------
module gng_ctrl import gng_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tuser,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic [4:0]  step_reg, step_next;
    logic        draw_reg, draw_next;
    logic        valid_reg, valid_next;
    logic        push;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            draw_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            draw_reg  <= draw_next;
            valid_reg <= valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        draw_next  = draw_reg;
        cmd        = '{op: OP_NONE, div_sel: DIV_72};
        s_tready   = 1'b0;
        push       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser) begin
                        state_next = ST_READ;
                        draw_next  = 1'b0;
                    end else begin
                        cmd.op = OP_LOAD;
                    end
                end
            end
            ST_READ: begin
                cmd.op     = OP_READ;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.op     = OP_UPDATE;
                state_next = ST_MIX;
            end
            ST_MIX: begin
                if (!draw_reg) begin
                    cmd.op     = OP_MIX_U1;
                    draw_next  = 1'b1;
                    state_next = ST_READ;
                end else begin
                    cmd.op     = OP_MIX_U2;
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                if (status.norm_done) begin
                    state_next = ST_LOG;
                    step_next  = '0;
                end else begin
                    cmd.op = OP_NORM;
                end
            end
            ST_LOG: begin
                cmd.op    = OP_LOG;
                step_next = step_reg + 5'd1;
                if (step_reg == LOG_LAST) begin
                    state_next = ST_TLOG;
                end
            end
            ST_TLOG: begin
                cmd.op     = OP_TLOG;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.op     = OP_SCALE;
                state_next = ST_SQRT;
                step_next  = '0;
            end
            ST_SQRT: begin
                cmd.op    = OP_SQRT;
                step_next = step_reg + 5'd1;
                if (step_reg == SQRT_LAST) begin
                    state_next = ST_TRIG;
                    step_next  = '0;
                end
            end
            ST_TRIG: begin
                cmd       = trig_cmd(step_reg);
                step_next = step_reg + 5'd1;
                if (step_reg == TRIG_LAST) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!valid_reg || m_tready) begin
                    cmd.op     = OP_PUSH;
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid
    always_comb begin
        if (push) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

@@ rtl/gaussian_noise_generator_top.sv @@
// sequence: a load item writes the table as it is accepted; a generate item runs
// two draws (read, update, mix), the leading-zero normalisation, 26 log squarings,
// log and scale, 29 square-root steps, 25 trig steps and the output load
// throughput: one generate item at a time, set by the single shared multiplier
// and the bit-serial log and root units; output register lets the next item in
// reset: synchronous active low; clears pointer, sequencer and std_dev to 5793
// ----------------------------------------------------------------------------
// gaussian_noise_generator_top
// Gaussian noise source: lagged-fibonacci uniform draws fed through a
// fixed point box-muller transform, scaled by a programmable std deviation.
// ----------------------------------------------------------------------------
module gaussian_noise_generator_top import gng_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // entry_index[7:0], entry_value[39:8]
    input  logic                  s_tuser,   // action: 0 load, 1 generate
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // gauss_first[23:0], gauss_second[47:24]
    input  logic                  cfg_we,
    input  logic [STD_W-1:0]      cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    gng_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // table and arithmetic
    gng_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

    // a generate item keeps the block busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input taken while generating");

    // a load item leaves the block ready for the next item
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> s_tready)
        else $error("load item stalled the block");

    // a result only appears at the end of a generate sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result raised without work");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian noise generator testbench
// Loads the lag table, then drives load and generate items with random bursts
// and output stalls. A built-in fixed point predictor computes each gaussian
// pair, and every result item is checked against the oldest expected pair.
// ----------------------------------------------------------------------------
module tb;
    import gng_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;    // entry_index[7:0], entry_value[39:8]
    logic                  s_tuser = 1'b0;  // action: 0 load, 1 generate
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // gauss_first[23:0], gauss_second[47:24]
    logic                  cfg_we = 1'b0;
    logic [STD_W-1:0]      cfg_wdata = '0;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_GEN  = 1'b1;
    localparam int   IDLE_LIMIT = 20000;

    // predictor state
    logic [31:0]      lag_mem [256];
    logic [7:0]       draw_ptr;
    logic [STD_W-1:0] sigma;
    logic [47:0]      pair_queue [$];
    int               err_count = 0;
    int               idle_cycles = 0;
    bit               stall_on = 1'b1;

    gaussian_noise_generator_top DUT (.*);

    always #2 aclk = ~aclk;

    function automatic logic [31:0] next_draw();
        logic [31:0] v;
        v = lag_mem[draw_ptr - LAG_A] + lag_mem[draw_ptr - LAG_B];
        lag_mem[draw_ptr] = v;
        v = v ^ lag_mem[draw_ptr - LAG_C];
        draw_ptr = draw_ptr + 8'd1;
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // sqrt(-2 ln u) in q.26
    function automatic logic [63:0] box_radius(input logic [31:0] x);
        int p;
        logic [63:0] m, fr, t, s;
        p = 31;
        fr = 0;
        while (x[p] == 1'b0) p--;
        m = 64'(x) << (31 - p);
        for (int k = 0; k < 26; k++) begin
            m = (m * m) >> 31;
            fr = fr << 1;
            if (m >= (64'd1 << 32)) begin
                fr[0] = 1'b1;
                m = m >> 1;
            end
        end
        t = (64'(32 - p) << 26) - fr;
        s = (t * TWO_LN2_Q30) >> 30;
        return int_sqrt(s << 26);
    endfunction

    function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    function automatic logic [23:0] scale_out(input logic [63:0] r, input logic [63:0] tr,
                                              input bit neg);
        logic [63:0] mag;
        mag = (q30_mul(r, tr) * sigma + (64'd1 << 25)) >> 26;
        if (neg) begin
            if (mag > 64'd8388608) mag = 64'd8388608;
            return 24'(64'd0 - mag);
        end
        if (mag > 64'd8388607) mag = 64'd8388607;
        return mag[23:0];
    endfunction

    function automatic logic [47:0] predict_pair();
        logic [31:0] x1, x2, f, g;
        logic [63:0] r, a, a2, t, sn, cs, cm, sm, one;
        logic [1:0]  q;
        one = 64'(ONE_Q30);
        x1 = next_draw();
        x2 = next_draw();
        if (x1 == 0) x1 = 32'd1;
        r = box_radius(x1);
        q = x2[31:30];
        f = {2'b00, x2[29:0]};
        g = (f >= 32'h2000_0000) ? (32'h4000_0000 - f) : f;
        a = (64'(g) * HALF_PI_Q30) >> 30;
        a2 = q30_mul(a, a);
        t = one - a2 / 72;
        t = one - q30_mul(a2, t) / 42;
        t = one - q30_mul(a2, t) / 20;
        t = one - q30_mul(a2, t) / 6;
        sn = q30_mul(a, t);
        t = one - a2 / 90;
        t = one - q30_mul(a2, t) / 56;
        t = one - q30_mul(a2, t) / 30;
        t = one - q30_mul(a2, t) / 12;
        cs = one - q30_mul(a2, t) / 2;
        if (f >= 32'h2000_0000) begin
            t = sn; sn = cs; cs = t;
        end
        if (q[0] == 1'b0) begin
            cm = cs; sm = sn;
        end else begin
            cm = sn; sm = cs;
        end
        return {scale_out(r, sm, !(q >= 2)), scale_out(r, cm, !(q == 1 || q == 2))};
    endfunction

    task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        err_count++;
    endtask

    // send one item, bursty gaps
    task automatic send_item(input logic act, input logic [7:0] idx, input logic [31:0] val);
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {val, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (act == ACT_LOAD) lag_mem[idx] = val;
        else pair_queue.push_back(predict_pair());
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pair_queue.size() != 0) @(negedge aclk);
        repeat (130) @(negedge aclk);
    endtask

    task automatic set_sigma(input logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sigma = v;
    endtask

    // every entry written once, so no unwritten read
    task automatic test_table_fill();
        for (int i = 0; i < 256; i++) send_item(ACT_LOAD, 8'(i), $urandom());
    endtask

    task automatic test_directed();
        send_item(ACT_GEN, 8'd0, 32'd0);
        send_item(ACT_LOAD, 8'hff, 32'hffff_ffff);
        send_item(ACT_LOAD, 8'h00, 32'h0000_0000);
        // zero first draw: both lag sources zero and the xor partner equal
        send_item(ACT_LOAD, draw_ptr - LAG_A, 32'd0);
        send_item(ACT_LOAD, draw_ptr - LAG_B, 32'd0);
        send_item(ACT_LOAD, draw_ptr - LAG_C, 32'd0);
        send_item(ACT_GEN, 8'd0, 32'd0);
        // tiny first draw drives the radius large
        send_item(ACT_LOAD, draw_ptr - LAG_A, 32'h1);
        send_item(ACT_LOAD, draw_ptr - LAG_B, 32'd0);
        send_item(ACT_LOAD, draw_ptr - LAG_C, 32'd0);
        send_item(ACT_GEN, 8'd0, 32'd0);
        for (int k = 0; k < 4; k++) send_item(ACT_GEN, 8'd0, 32'd0);
    endtask

    task automatic test_random(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) send_item(ACT_LOAD, 8'($urandom()), $urandom());
            else send_item(ACT_GEN, 8'($urandom()), $urandom());
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        logic [47:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pair_queue.size() == 0) begin
                report("unexpected item", m_tdata, '0);
            end else begin
                want = pair_queue.pop_front();
                if (m_tdata[23:0] != want[23:0]) report("gauss_first", m_tdata, want);
                if (m_tdata[47:24] != want[47:24]) report("gauss_second", m_tdata, want);
            end
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if (!stall_on) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 2) != 0);
    end

    // watchdog on accepted items
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        draw_ptr = 0;
        sigma = STD_RESET;
        foreach (lag_mem[i]) lag_mem[i] = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_table_fill();
        test_directed();
        set_sigma(16'hffff);
        test_directed();
        set_sigma(16'd0);
        test_random(30);
        set_sigma(16'd4096);
        stall_on = 1'b0;
        test_random(200);
        stall_on = 1'b1;
        set_sigma(16'($urandom()));
        test_random(400);
        set_sigma(STD_RESET);
        test_random(400);
        drain();
        if (err_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/gng_pkg.sv
rtl/gng_datapath.sv
rtl/gng_ctrl.sv
rtl/gaussian_noise_generator_top.sv
tb/sv/tb.sv
